>>> rtl/wavp_pkg.sv
package wavp_pkg;

   // parser phases
   typedef enum logic [3:0] {
      PhRiff  = 4'd0,
      PhRsize = 4'd1,
      PhWave  = 4'd2,
      PhHdr   = 4'd3,
      PhFmt   = 4'd4,
      PhSkip  = 4'd5,
      PhData  = 4'd6,
      PhDone  = 4'd7,
      PhErr   = 4'd8
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      KindFormat = 2'd0,
      KindSample = 2'd1,
      KindError  = 2'd2
   } kind_type;

   // error codes
   typedef enum logic [2:0] {
      ErrTag         = 3'd0,
      ErrFmtShort    = 3'd1,
      ErrFmtTag      = 3'd2,
      ErrNoFrame     = 3'd3,
      ErrUnsupported = 3'd4
   } err_type;

   localparam logic [31:0] TagRiff = 32'h5249_4646;
   localparam logic [31:0] TagWave = 32'h5741_5645;
   localparam logic [31:0] TagFmt  = 32'h666D_7420;
   localparam logic [31:0] TagData = 32'h6461_7461;

   localparam logic [15:0] FmtTagPcm = 16'h0001;
   localparam logic [15:0] FmtTagExt = 16'hFFFE;
   localparam logic [31:0] FmtBodyBytes = 32'd16;
   localparam logic [15:0] MaxChannels = 16'd8;

   // parser state carried from beat to beat
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  cnt;
      logic [31:0] tag;
      logic [31:0] len;
      logic [31:0] skip;
      logic        fmt_seen;
      logic [15:0] chans;
      logic [31:0] rate;
      logic [15:0] width;
      logic [31:0] remain;
      logic [23:0] sample_asm;
      logic [1:0]  bis;
      logic [2:0]  chan;
   } state_type;

   localparam state_type StateReset = '{
      phase: PhRiff, cnt: 4'd0, tag: 32'd0, len: 32'd0, skip: 32'd0,
      fmt_seen: 1'b0, chans: 16'd0, rate: 32'd0, width: 16'd0,
      remain: 32'd0, sample_asm: 24'd0, bis: 2'd0, chan: 3'd0
   };

   // one result beat
   typedef struct packed {
      kind_type           kind;
      logic [3:0]         channel_count;
      logic [31:0]        sample_rate;
      logic [5:0]         sample_bits;
      logic [31:0]        data_bytes;
      logic signed [31:0] sample_value;
      logic [2:0]         channel_index;
      logic               last_sample;
      err_type            error_code;
   } result_type;

   localparam result_type ResultZero = '{
      kind: KindFormat, channel_count: 4'd0, sample_rate: 32'd0,
      sample_bits: 6'd0, data_bytes: 32'd0, sample_value: 32'sd0,
      channel_index: 3'd0, last_sample: 1'b0, error_code: ErrTag
   };

endpackage

>>> rtl/wavp_step.sv
module wavp_step (
   input  wavp_pkg::state_type  st,
   input  logic [7:0]           in_byte,
   input  logic                 restart,
   output wavp_pkg::state_type  st_nx,
   output logic                 res_valid,
   output wavp_pkg::result_type res
);

   wavp_pkg::state_type cur;
   logic [31:0] tag_shift;
   logic [31:0] hdr_len_nx;
   logic [31:0] hdr_skip;
   logic [31:0] fmt_skip;
   logic [15:0] fmt_code;
   logic        fmt_code_bad;
   logic [2:0]  bps;
   logic [6:0]  frame;
   logic        no_frame;
   logic        unsupported;
   logic [31:0] remain_dec;
   logic [31:0] full_word;
   logic [31:0] sample_word;
   logic        sample_done;
   logic [3:0]  chan_inc;
   logic        frame_end;
   logic        last_whole;
   logic [31:0] skip_dec;

   // restart takes this byte as the first file byte
   assign cur = restart ? wavp_pkg::StateReset : st;

   // shared datapath pieces
   assign tag_shift  = {cur.tag[23:0], in_byte};
   assign hdr_len_nx = cur.len | ({24'd0, in_byte} << {cur.cnt[1:0], 3'b000});
   assign hdr_skip   = (&hdr_len_nx) ? 32'hFFFF_FFFF
                                     : hdr_len_nx + {31'd0, hdr_len_nx[0]};
   assign fmt_skip   = cur.len - wavp_pkg::FmtBodyBytes + {31'd0, cur.len[0]};
   assign fmt_code   = {in_byte, cur.tag[7:0]};
   assign fmt_code_bad = (fmt_code != wavp_pkg::FmtTagPcm) &&
                         (fmt_code != wavp_pkg::FmtTagExt);
   assign bps        = cur.width[5:3];
   assign frame      = {4'd0, bps} * {3'd0, cur.chans[3:0]};
   assign no_frame   = (cur.width < 16'd8) || (cur.chans == 16'd0);
   assign unsupported = ((cur.width != 16'd8) && (cur.width != 16'd16) &&
                         (cur.width != 16'd24) && (cur.width != 16'd32)) ||
                        (cur.chans > wavp_pkg::MaxChannels);
   assign skip_dec   = cur.skip - 32'd1;

   // sample assembly
   assign remain_dec  = cur.remain - 32'd1;
   assign sample_done = ({1'b0, cur.bis} + 3'd1) >= bps;
   assign full_word   = {8'd0, cur.sample_asm} | ({24'd0, in_byte} << {cur.bis, 3'b000});
   assign chan_inc    = {1'b0, cur.chan} + 4'd1;
   assign frame_end   = {12'd0, chan_inc} >= cur.chans;
   assign last_whole  = frame_end && (remain_dec < {25'd0, frame});

   always_comb begin
      case (bps)
         3'd1:    sample_word = {~full_word[7], full_word[6:0], 24'd0};
         3'd2:    sample_word = {full_word[15:0], 16'd0};
         3'd3:    sample_word = {full_word[23:0], 8'd0};
         default: sample_word = full_word;
      endcase
   end

   // next state
   always_comb begin
      st_nx = cur;
      case (cur.phase)
         wavp_pkg::PhRiff, wavp_pkg::PhWave: begin
            st_nx.tag = tag_shift;
            st_nx.cnt = cur.cnt + 4'd1;
            if (cur.cnt == 4'd3) begin
               if (cur.phase == wavp_pkg::PhRiff) begin
                  if (tag_shift != wavp_pkg::TagRiff) begin
                     st_nx.phase = wavp_pkg::PhErr;
                  end else begin
                     st_nx.phase = wavp_pkg::PhRsize;
                     st_nx.cnt   = 4'd0;
                     st_nx.tag   = 32'd0;
                  end
               end else begin
                  if (tag_shift != wavp_pkg::TagWave) begin
                     st_nx.phase = wavp_pkg::PhErr;
                  end else begin
                     st_nx.phase = wavp_pkg::PhHdr;
                     st_nx.cnt   = 4'd0;
                     st_nx.tag   = 32'd0;
                     st_nx.len   = 32'd0;
                  end
               end
            end
         end
         wavp_pkg::PhRsize: begin
            st_nx.cnt = cur.cnt + 4'd1;
            if (cur.cnt == 4'd3) begin
               st_nx.phase = wavp_pkg::PhWave;
               st_nx.cnt   = 4'd0;
               st_nx.tag   = 32'd0;
            end
         end
         wavp_pkg::PhHdr: begin
            if (cur.cnt < 4'd4) begin
               st_nx.tag = tag_shift;
            end else begin
               st_nx.len = hdr_len_nx;
            end
            st_nx.cnt = cur.cnt + 4'd1;
            if (cur.cnt == 4'd7) begin
               st_nx.cnt = 4'd0;
               if (cur.tag == wavp_pkg::TagFmt) begin
                  if (hdr_len_nx < wavp_pkg::FmtBodyBytes) begin
                     st_nx.phase = wavp_pkg::PhErr;
                  end else begin
                     st_nx.phase = wavp_pkg::PhFmt;
                     st_nx.chans = 16'd0;
                     st_nx.rate  = 32'd0;
                     st_nx.width = 16'd0;
                     st_nx.tag   = 32'd0;
                  end
               end else if (cur.tag == wavp_pkg::TagData) begin
                  if (!cur.fmt_seen || no_frame || unsupported) begin
                     st_nx.phase = wavp_pkg::PhErr;
                  end else begin
                     st_nx.remain     = hdr_len_nx;
                     st_nx.sample_asm = 24'd0;
                     st_nx.bis        = 2'd0;
                     st_nx.chan       = 3'd0;
                     st_nx.phase      = (hdr_len_nx < {25'd0, frame}) ?
                                        wavp_pkg::PhDone : wavp_pkg::PhData;
                  end
               end else if (hdr_skip == 32'd0) begin
                  st_nx.tag = 32'd0;
                  st_nx.len = 32'd0;
               end else begin
                  st_nx.phase = wavp_pkg::PhSkip;
                  st_nx.skip  = hdr_skip;
               end
            end
         end
         wavp_pkg::PhFmt: begin
            case (cur.cnt)
               4'd0:  st_nx.tag[7:0]    = in_byte;
               4'd1:  st_nx.tag[15:8]   = in_byte;
               4'd2:  st_nx.chans[7:0]  = in_byte;
               4'd3:  st_nx.chans[15:8] = in_byte;
               4'd4:  st_nx.rate[7:0]   = in_byte;
               4'd5:  st_nx.rate[15:8]  = in_byte;
               4'd6:  st_nx.rate[23:16] = in_byte;
               4'd7:  st_nx.rate[31:24] = in_byte;
               4'd14: st_nx.width[7:0]  = in_byte;
               4'd15: st_nx.width[15:8] = in_byte;
               default: st_nx.tag = cur.tag;
            endcase
            st_nx.cnt = cur.cnt + 4'd1;
            if ((cur.cnt == 4'd1) && fmt_code_bad) begin
               st_nx.phase = wavp_pkg::PhErr;
            end else if (cur.cnt == 4'd15) begin
               st_nx.cnt      = 4'd0;
               st_nx.fmt_seen = 1'b1;
               if (fmt_skip == 32'd0) begin
                  st_nx.phase = wavp_pkg::PhHdr;
                  st_nx.tag   = 32'd0;
                  st_nx.len   = 32'd0;
               end else begin
                  st_nx.phase = wavp_pkg::PhSkip;
                  st_nx.skip  = fmt_skip;
               end
            end
         end
         wavp_pkg::PhSkip: begin
            st_nx.skip = skip_dec;
            if (skip_dec == 32'd0) begin
               st_nx.phase = wavp_pkg::PhHdr;
               st_nx.cnt   = 4'd0;
               st_nx.tag   = 32'd0;
               st_nx.len   = 32'd0;
            end
         end
         wavp_pkg::PhData: begin
            st_nx.remain = remain_dec;
            if (!sample_done) begin
               st_nx.sample_asm = full_word[23:0];
               st_nx.bis        = cur.bis + 2'd1;
            end else begin
               st_nx.sample_asm = 24'd0;
               st_nx.bis        = 2'd0;
               st_nx.chan       = frame_end ? 3'd0 : chan_inc[2:0];
               if (last_whole) begin
                  st_nx.phase = wavp_pkg::PhDone;
               end
            end
         end
         default: st_nx = cur;
      endcase
   end

   // result beat
   always_comb begin
      res_valid = 1'b0;
      res       = wavp_pkg::ResultZero;
      case (cur.phase)
         wavp_pkg::PhRiff, wavp_pkg::PhWave: begin
            if ((cur.cnt == 4'd3) &&
                (((cur.phase == wavp_pkg::PhRiff) && (tag_shift != wavp_pkg::TagRiff)) ||
                 ((cur.phase == wavp_pkg::PhWave) && (tag_shift != wavp_pkg::TagWave)))) begin
               res_valid      = 1'b1;
               res.kind       = wavp_pkg::KindError;
               res.error_code = wavp_pkg::ErrTag;
            end
         end
         wavp_pkg::PhHdr: begin
            if (cur.cnt == 4'd7) begin
               if (cur.tag == wavp_pkg::TagFmt) begin
                  if (hdr_len_nx < wavp_pkg::FmtBodyBytes) begin
                     res_valid      = 1'b1;
                     res.kind       = wavp_pkg::KindError;
                     res.error_code = wavp_pkg::ErrFmtShort;
                  end
               end else if (cur.tag == wavp_pkg::TagData) begin
                  res_valid = 1'b1;
                  if (!cur.fmt_seen || no_frame) begin
                     res.kind       = wavp_pkg::KindError;
                     res.error_code = wavp_pkg::ErrNoFrame;
                  end else if (unsupported) begin
                     res.kind       = wavp_pkg::KindError;
                     res.error_code = wavp_pkg::ErrUnsupported;
                  end else begin
                     res.kind          = wavp_pkg::KindFormat;
                     res.channel_count = cur.chans[3:0];
                     res.sample_rate   = cur.rate;
                     res.sample_bits   = cur.width[5:0];
                     res.data_bytes    = hdr_len_nx;
                  end
               end
            end
         end
         wavp_pkg::PhFmt: begin
            if ((cur.cnt == 4'd1) && fmt_code_bad) begin
               res_valid      = 1'b1;
               res.kind       = wavp_pkg::KindError;
               res.error_code = wavp_pkg::ErrFmtTag;
            end
         end
         wavp_pkg::PhData: begin
            if (sample_done) begin
               res_valid         = 1'b1;
               res.kind          = wavp_pkg::KindSample;
               res.sample_value  = sample_word;
               res.channel_index = cur.chan;
               res.last_sample   = last_whole;
            end
         end
         default: res_valid = 1'b0;
      endcase
   end

endmodule

>>> rtl/wav_header_and_pcm_unpacker.sv
// channel | direction | ports                                   | beat
// req     | in        | req_valid/req_ready, in_byte, restart   | one file byte
// rsp     | out       | rsp_valid/rsp_ready, result fields      | format, sample or error
//
// one byte is taken per cycle while req_ready is high; the parse state updates in the same cycle
// and at most one result lands in the output register
// req_ready is high whenever the output register is empty or being drained
// synchronous active-high reset returns the parser to the riff tag check
// a stall on rsp with a result held blocks every input byte until that result is taken
module wav_header_and_pcm_unpacker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [3:0]         rsp_channel_count,
   output logic [31:0]        rsp_sample_rate,
   output logic [5:0]         rsp_sample_bits,
   output logic [31:0]        rsp_data_bytes,
   output logic signed [31:0] rsp_sample_value,
   output logic [2:0]         rsp_channel_index,
   output logic               rsp_last_sample,
   output logic [2:0]         rsp_error_code
);

   wavp_pkg::state_type  st_ff;
   wavp_pkg::state_type  st_in;
   wavp_pkg::state_type  step_nx;
   wavp_pkg::result_type out_ff;
   wavp_pkg::result_type out_in;
   wavp_pkg::result_type step_res;
   logic                 step_valid;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 accept;

   wavp_step u_step (
      .st        (st_ff),
      .in_byte   (req_in_byte),
      .restart   (req_restart),
      .st_nx     (step_nx),
      .res_valid (step_valid),
      .res       (step_res)
   );

   // handshake
   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // next values
   always_comb begin
      st_in        = accept ? step_nx : st_ff;
      out_in       = (accept && step_valid) ? step_res : out_ff;
      out_valid_in = (accept && step_valid) ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= wavp_pkg::StateReset;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_ff.kind;
   assign rsp_channel_count = out_ff.channel_count;
   assign rsp_sample_rate   = out_ff.sample_rate;
   assign rsp_sample_bits   = out_ff.sample_bits;
   assign rsp_data_bytes    = out_ff.data_bytes;
   assign rsp_sample_value  = out_ff.sample_value;
   assign rsp_channel_index = out_ff.channel_index;
   assign rsp_last_sample   = out_ff.last_sample;
   assign rsp_error_code    = out_ff.error_code;

endmodule

>>> rtl/wavp_checker.sv
module wavp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_result_kind,
   input logic [3:0]         rsp_channel_count,
   input logic [31:0]        rsp_sample_rate,
   input logic [5:0]         rsp_sample_bits,
   input logic [31:0]        rsp_data_bytes,
   input logic signed [31:0] rsp_sample_value,
   input logic [2:0]         rsp_channel_index,
   input logic               rsp_last_sample,
   input logic [2:0]         rsp_error_code
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_value) &&
                                  $stable(rsp_result_kind) && $stable(rsp_data_bytes))
      else $error("stalled result beat changed");

   // an empty output register never blocks input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // format beats carry a supported layout
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == wavp_pkg::KindFormat) |->
         ((rsp_sample_bits == 6'd8) || (rsp_sample_bits == 6'd16) ||
          (rsp_sample_bits == 6'd24) || (rsp_sample_bits == 6'd32)) &&
         (rsp_channel_count != 4'd0) && (rsp_channel_count <= 4'd8) &&
         (rsp_sample_value == 32'sd0))
      else $error("bad format beat");

   // non-sample beats leave sample fields clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != wavp_pkg::KindSample) |->
         !rsp_last_sample && (rsp_channel_index == 3'd0))
      else $error("sample fields set on non-sample beat");

   // sample beats leave format and error fields clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == wavp_pkg::KindSample) |->
         (rsp_data_bytes == 32'd0) && (rsp_error_code == 3'd0) &&
         (rsp_sample_rate == 32'd0) && (rsp_channel_count == 4'd0) &&
         (rsp_sample_bits == 6'd0))
      else $error("format fields set on sample beat");

endmodule

bind wav_header_and_pcm_unpacker wavp_checker u_checker (.*);

>>> sim/wav_header_and_pcm_unpacker_test.sv
module wav_header_and_pcm_unpacker_test;
   import wavp_pkg::*;

   localparam int ByteTarget  = 1700;
   localparam int IdleLimit   = 2000;
   localparam int HoldCycles  = 300;
   localparam int DrainCycles = 8;
   localparam int PrintLimit  = 100;

   // chunk tags that the parser only skips
   localparam logic [31:0] TagList = 32'h4C49_5354;
   localparam logic [31:0] TagId3  = 32'h6964_3320;
   localparam logic [31:0] TagJunk = 32'h4A55_4E4B;

   typedef struct packed {
      logic [7:0] value;
      logic       restart;
   } file_byte_type;

   // kinds of generated files
   typedef enum int {
      ScnGood,
      ScnBadRiff,
      ScnBadWave,
      ScnFmtShort,
      ScnBadFmtTag,
      ScnDataFirst,
      ScnZeroFrame,
      ScnBadWidth,
      ScnManyChans,
      ScnHugeSkip,
      ScnNoise,
      ScnCount
   } scenario_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_in_byte = 8'd0;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_result_kind;
   logic [3:0]         rsp_channel_count;
   logic [31:0]        rsp_sample_rate;
   logic [5:0]         rsp_sample_bits;
   logic [31:0]        rsp_data_bytes;
   logic signed [31:0] rsp_sample_value;
   logic [2:0]         rsp_channel_index;
   logic               rsp_last_sample;
   logic [2:0]         rsp_error_code;

   file_byte_type byte_queue[$];
   result_type    expected_results[$];

   logic restart_pending = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   int   mismatch_count = 0;
   int   results_checked = 0;
   int   format_count = 0;
   int   sample_count = 0;
   int   error_count = 0;
   int   files_built = 0;
   int   stim_bytes = 0;
   int   bytes_sent = 0;

   // parser model state
   phase_type   pm_phase;
   int unsigned pm_cnt;
   logic [31:0] pm_tag;
   logic [31:0] pm_len;
   logic [31:0] pm_skip;
   logic        pm_fmt_seen;
   logic [15:0] pm_chans;
   logic [31:0] pm_rate;
   logic [15:0] pm_width;
   logic [31:0] pm_remain;
   logic [31:0] pm_asm;
   int unsigned pm_bis;
   int unsigned pm_chan;

   wav_header_and_pcm_unpacker dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void parser_clear();
      pm_phase    = PhRiff;
      pm_cnt      = 0;
      pm_tag      = '0;
      pm_len      = '0;
      pm_skip     = '0;
      pm_fmt_seen = 1'b0;
      pm_chans    = '0;
      pm_rate     = '0;
      pm_width    = '0;
      pm_remain   = '0;
      pm_asm      = '0;
      pm_bis      = 0;
      pm_chan     = 0;
   endfunction

   // error result; the parser then ignores bytes until restart
   function automatic result_type flag_error(input err_type code);
      result_type r;
      r = ResultZero;
      r.kind = KindError;
      r.error_code = code;
      pm_phase = PhErr;
      return r;
   endfunction

   function automatic void open_chunk_header();
      pm_phase = PhHdr;
      pm_cnt   = 0;
      pm_tag   = '0;
      pm_len   = '0;
   endfunction

   // padded skip length saturates at 32 bits
   function automatic void begin_skip(input logic [32:0] span);
      logic [32:0] clipped;
      clipped = (span > 33'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : span;
      pm_skip = clipped[31:0];
      if (pm_skip == 0) open_chunk_header();
      else pm_phase = PhSkip;
   endfunction

   // advance the parser by one file byte; returns 1 when a result is due
   function automatic bit parse_byte(input logic [7:0] b, input logic rs,
                                     output result_type r);
      int unsigned n;
      int unsigned idx;
      logic [31:0] bps;
      logic [31:0] frame;
      logic [31:0] whole;
      logic [31:0] v;
      r = ResultZero;
      if (rs) parser_clear();
      n = pm_cnt;
      case (pm_phase)
         PhRiff, PhWave: begin
            pm_tag = {pm_tag[23:0], b};
            pm_cnt++;
            if (pm_cnt >= 4) begin
               if (pm_tag != ((pm_phase == PhRiff) ? TagRiff : TagWave)) begin
                  r = flag_error(ErrTag);
                  return 1'b1;
               end
               if (pm_phase == PhRiff) begin
                  pm_phase = PhRsize;
                  pm_cnt = 0;
                  pm_tag = '0;
               end else begin
                  open_chunk_header();
               end
            end
         end
         PhRsize: begin
            pm_cnt++;
            if (pm_cnt >= 4) begin
               pm_phase = PhWave;
               pm_cnt = 0;
               pm_tag = '0;
            end
         end
         PhHdr: begin
            if (n < 4) pm_tag = {pm_tag[23:0], b};
            else pm_len |= 32'(b) << (8 * ((n - 4) % 4));
            pm_cnt = n + 1;
            if (pm_cnt >= 8) begin
               pm_cnt = 0;
               if (pm_tag == TagFmt) begin
                  if (pm_len < FmtBodyBytes) begin
                     r = flag_error(ErrFmtShort);
                     return 1'b1;
                  end
                  pm_phase = PhFmt;
                  pm_chans = '0;
                  pm_rate  = '0;
                  pm_width = '0;
                  pm_tag   = '0;
               end else if (pm_tag == TagData) begin
                  // data header: fmt seen, nonzero frame, supported layout
                  if (!pm_fmt_seen) begin
                     r = flag_error(ErrNoFrame);
                     return 1'b1;
                  end
                  bps = 32'(pm_width) / 8;
                  frame = bps * 32'(pm_chans);
                  if (frame == 0) begin
                     r = flag_error(ErrNoFrame);
                     return 1'b1;
                  end
                  if (!(pm_width inside {16'd8, 16'd16, 16'd24, 16'd32}) ||
                      pm_chans > MaxChannels) begin
                     r = flag_error(ErrUnsupported);
                     return 1'b1;
                  end
                  r.kind          = KindFormat;
                  r.channel_count = pm_chans[3:0];
                  r.sample_rate   = pm_rate;
                  r.sample_bits   = pm_width[5:0];
                  r.data_bytes    = pm_len;
                  whole = pm_len - (pm_len % frame);
                  pm_remain = whole;
                  pm_asm  = '0;
                  pm_bis  = 0;
                  pm_chan = 0;
                  pm_phase = (whole == 0) ? PhDone : PhData;
                  return 1'b1;
               end else begin
                  begin_skip({1'b0, pm_len} + 33'(pm_len[0]));
               end
            end
         end
         PhFmt: begin
            if (n < 2) begin
               pm_tag |= 32'(b) << (8 * n);
               if (n == 1 && pm_tag != 32'(FmtTagPcm) && pm_tag != 32'(FmtTagExt)) begin
                  r = flag_error(ErrFmtTag);
                  return 1'b1;
               end
            end else if (n < 4) begin
               pm_chans |= 16'(b) << (8 * (n - 2));
            end else if (n < 8) begin
               pm_rate |= 32'(b) << (8 * (n - 4));
            end else if (n >= 14) begin
               pm_width |= 16'(b) << (8 * ((n - 14) % 2));
            end
            pm_cnt = n + 1;
            if (pm_cnt >= 16) begin
               pm_cnt = 0;
               pm_fmt_seen = 1'b1;
               begin_skip({1'b0, pm_len - FmtBodyBytes} + 33'(pm_len[0]));
            end
         end
         PhSkip: begin
            if (pm_skip > 0) pm_skip--;
            if (pm_skip == 0) open_chunk_header();
         end
         PhData: begin
            bps = (32'(pm_width) / 8) % 8;
            if (bps == 0 || bps > 4) bps = 4;
            idx = pm_bis % 4;
            pm_remain = pm_remain - 1;
            if (idx + 1 < bps) begin
               pm_asm |= 32'(b) << (8 * idx);
               pm_bis = idx + 1;
            end else begin
               // left-justify; 8-bit pcm is offset binary
               v = (pm_asm | (32'(b) << (8 * idx))) << (8 * (4 - bps));
               if (bps == 1) v ^= 32'h8000_0000;
               pm_asm = '0;
               pm_bis = 0;
               r.kind          = KindSample;
               r.sample_value  = v;
               r.channel_index = 3'(pm_chan);
               r.last_sample   = (pm_remain == 0);
               pm_chan++;
               if (pm_chan >= pm_chans) pm_chan = 0;
               if (pm_remain == 0) pm_phase = PhDone;
               return 1'b1;
            end
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PrintLimit)
         $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
                  results_checked, what, got, want);
   endtask

   // stimulus building
   task automatic push_byte(input logic [7:0] v);
      byte_queue.push_back('{value: v, restart: restart_pending});
      restart_pending = 1'b0;
      stim_bytes++;
   endtask

   task automatic push_word_le(input logic [31:0] v, input int count);
      for (int i = 0; i < count; i++) push_byte(v[8*i +: 8]);
   endtask

   task automatic push_tag(input logic [31:0] t);
      push_byte(t[31:24]);
      push_byte(t[23:16]);
      push_byte(t[15:8]);
      push_byte(t[7:0]);
   endtask

   task automatic push_chunk_head(input logic [31:0] t, input logic [31:0] len);
      push_tag(t);
      push_word_le(len, 4);
   endtask

   function automatic logic [31:0] pick_junk_tag();
      case ($urandom_range(0, 3))
         0: return TagList;
         1: return TagId3;
         2: return TagJunk;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pcm_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_junk();
      logic [31:0] len;
      len = $urandom_range(0, 9);
      push_chunk_head(pick_junk_tag(), len);
      repeat (len + 32'(len[0])) push_byte($urandom);
   endtask

   task automatic push_fmt(input logic [15:0] ftag, input logic [15:0] chans,
                           input logic [31:0] rate, input logic [15:0] width,
                           input logic [31:0] len);
      push_chunk_head(TagFmt, len);
      push_word_le(32'(ftag), 2);
      push_word_le(32'(chans), 2);
      push_word_le(rate, 4);
      // byte rate and block align are not checked
      push_word_le($urandom, 4);
      push_word_le($urandom, 2);
      push_word_le(32'(width), 2);
      if (len >= 16) repeat (len - 16 + 32'(len[0])) push_byte($urandom);
   endtask

   // one file; a restart marks its first byte, but noise files place restarts at random
   task automatic build_file(input scenario_type scn);
      logic [15:0] chans;
      logic [15:0] width;
      logic [15:0] ftag;
      logic [31:0] rate;
      logic [31:0] len;
      logic [31:0] cut;
      int          frame;
      restart_pending = 1'b1;
      files_built++;
      if (scn == ScnNoise) begin
         repeat ($urandom_range(4, 20)) begin
            restart_pending = $urandom_range(0, 1);
            push_byte($urandom);
         end
         return;
      end
      if (scn == ScnBadRiff) begin
         push_tag(TagRiff ^ (32'd1 << $urandom_range(0, 31)));
      end else begin
         push_tag(TagRiff);
         push_word_le($urandom, 4);
         push_tag((scn == ScnBadWave) ? TagWave ^ (32'd1 << $urandom_range(0, 31)) : TagWave);
      end
      if (scn != ScnBadRiff && scn != ScnBadWave) begin
         chans = 16'($urandom_range(1, 8));
         if ($urandom_range(0, 1) == 1) chans = 16'($urandom_range(1, 2));
         width = 16'(8 * $urandom_range(1, 4));
         ftag = ($urandom_range(0, 1) == 1) ? FmtTagPcm : FmtTagExt;
         case ($urandom_range(0, 4))
            0: rate = 32'd0;
            1: rate = 32'hFFFF_FFFF;
            2: rate = 32'd48000;
            default: rate = $urandom;
         endcase
         len = ($urandom_range(0, 1) == 1) ? 32'd16 : 32'($urandom_range(17, 25));
         case (scn)
            ScnFmtShort: len = $urandom_range(0, 15);
            ScnBadFmtTag: ftag = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(2, 65533))
                                                            : 16'h0000;
            ScnZeroFrame: begin
               if ($urandom_range(0, 1) == 1) chans = 16'd0;
               else width = 16'($urandom_range(0, 7));
            end
            ScnBadWidth: begin
               case ($urandom_range(0, 3))
                  0: width = 16'd12;
                  1: width = 16'd20;
                  2: width = 16'd40;
                  default: width = 16'($urandom_range(33, 65535));
               endcase
            end
            ScnManyChans: chans = ($urandom_range(0, 1) == 1) ? 16'd9
                                                              : 16'($urandom_range(9, 65535));
            default: begin
            end
         endcase
         repeat ($urandom_range(0, 2)) push_junk();
         if (scn != ScnDataFirst) begin
            // sometimes an earlier fmt chunk that the second one overrides
            if (scn == ScnGood && $urandom_range(0, 99) < 15)
               push_fmt(FmtTagPcm, 16'($urandom_range(1, 8)), $urandom,
                        16'(8 * $urandom_range(1, 4)), 32'd16);
            push_fmt(ftag, chans, rate, width, len);
            if ($urandom_range(0, 3) == 0) push_junk();
         end
         if (scn == ScnHugeSkip) begin
            push_chunk_head(pick_junk_tag(), 32'hFFFF_FFFF - 32'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 6)) push_byte($urandom);
            return;
         end
         if (scn == ScnGood) begin
            frame = (int'(width) / 8) * int'(chans);
            if ($urandom_range(0, 9) == 0) begin
               // huge declared size, cut short by the next restart
               len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom;
               cut = $urandom_range(0, 40);
            end else begin
               len = ($urandom_range(0, 99) < 15) ? 32'd0
                     : 32'($urandom_range(1, 48 / frame) * frame);
               len = len + 32'($urandom_range(0, frame - 1));
               cut = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, len)) : len;
            end
            push_chunk_head(TagData, len);
            repeat (cut) push_byte(pcm_byte());
         end else begin
            push_chunk_head(TagData, $urandom_range(0, 64));
         end
      end
      // trailing bytes with no restart mark after the file
      repeat ($urandom_range(0, 3)) byte_queue.push_back('{value: 8'($urandom), restart: 1'b0});
   endtask

   // one idling phase: build files up to the quota, then let everything drain
   task automatic run_phase(input int send_pct, input int recv_pct, input int quota,
                            input bit squeeze);
      int goal;
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      if (squeeze) hold_requests++;
      goal = stim_bytes + quota;
      while (stim_bytes < goal) begin
         if (files_built < ScnCount) build_file(scenario_type'(files_built));
         else if ($urandom_range(0, 99) < 55) build_file(ScnGood);
         else build_file(scenario_type'($urandom_range(1, ScnCount - 1)));
      end
      while (byte_queue.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // byte driver; the parser model advances on each accepted beat
   always @(posedge clock) begin
      result_type predicted;
      logic       offer;
      if (reset) begin
         req_valid <= 1'b0;
         parser_clear();
      end else begin
         if (req_valid && req_ready) begin
            bytes_sent++;
            if (parse_byte(req_in_byte, req_restart, predicted))
               expected_results.push_back(predicted);
         end
         if (!req_valid || req_ready) begin
            offer = byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
            if (offer) begin
               req_in_byte <= byte_queue[0].value;
               req_restart <= byte_queue[0].restart;
               void'(byte_queue.pop_front());
            end
            req_valid <= offer;
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      result_type want;
      logic       ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 32'(rsp_result_kind), 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind != want.kind)
                  report_mismatch("result_kind", 32'(rsp_result_kind), 32'(want.kind));
               if (rsp_channel_count != want.channel_count)
                  report_mismatch("channel_count", 32'(rsp_channel_count),
                                  32'(want.channel_count));
               if (rsp_sample_rate != want.sample_rate)
                  report_mismatch("sample_rate", rsp_sample_rate, want.sample_rate);
               if (rsp_sample_bits != want.sample_bits)
                  report_mismatch("sample_bits", 32'(rsp_sample_bits), 32'(want.sample_bits));
               if (rsp_data_bytes != want.data_bytes)
                  report_mismatch("data_bytes", rsp_data_bytes, want.data_bytes);
               if (rsp_sample_value != want.sample_value)
                  report_mismatch("sample_value", rsp_sample_value, want.sample_value);
               if (rsp_channel_index != want.channel_index)
                  report_mismatch("channel_index", 32'(rsp_channel_index),
                                  32'(want.channel_index));
               if (rsp_last_sample != want.last_sample)
                  report_mismatch("last_sample", 32'(rsp_last_sample), 32'(want.last_sample));
               if (rsp_error_code != want.error_code)
                  report_mismatch("error_code", 32'(rsp_error_code), 32'(want.error_code));
               case (want.kind)
                  KindFormat: format_count++;
                  KindSample: sample_count++;
                  default:    error_count++;
               endcase
            end
         end
         // long hold-off so the output register fills and blocks the input
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = $urandom_range(0, 99) >= recv_stall_pct;
         end
         rsp_ready <= ready_next;
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("timeout: %0d cycles without a beat, %0d results outstanding",
                  quiet_cycles, expected_results.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: riff tag off in its last byte, bytes ignored after an error,
      // wave tag off after an all-ones riff size, lone restart byte
      restart_pending = 1'b1;
      push_tag(32'h5249_4658);
      byte_queue.push_back('{value: 8'h00, restart: 1'b0});
      byte_queue.push_back('{value: 8'hFF, restart: 1'b0});
      restart_pending = 1'b1;
      push_tag(TagRiff);
      push_word_le(32'hFFFF_FFFF, 4);
      push_tag(TagWave ^ 32'h0000_0001);
      restart_pending = 1'b1;
      push_byte(8'hFF);

      run_phase(0, 0, 400, 1'b0);
      run_phase(67, 0, 400, 1'b0);
      run_phase(0, 67, 450, 1'b1);
      run_phase(31, 31, ByteTarget - stim_bytes, 1'b0);

      // settle with the receiver always ready so a stray result shows up
      recv_stall_pct = 0;
      repeat (DrainCycles) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", expected_results.size(), 32'd0);

      $display("covered %0d files, %0d bytes sent under quiet, sender-idle, receiver-stall",
               files_built, bytes_sent);
      $display("and mixed idling; checked %0d format, %0d sample, %0d error results, %0d mismatches",
               format_count, sample_count, error_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
